// ===== rtl/core/ttws_pkg.sv =====
// Shared types and constants for the task table weighted scheduler.
package ttws_pkg;

    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 5;
    localparam int SLOT_W   = 5;
    localparam int TICK_W   = 16;
    localparam int RT_W     = 32;
    localparam int CODE_W   = 3;
    localparam int CHOSEN_W = 5;
    localparam int WIDE_W   = 9;
    localparam int PROD_W   = RT_W + PRIO_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHARGE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RETIRE   = 2'd3;

    // Result codes
    localparam logic [CODE_W-1:0] CODE_OK       = 3'd0;
    localparam logic [CODE_W-1:0] CODE_BAD_PRIO = 3'd1;
    localparam logic [CODE_W-1:0] CODE_FULL     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_BAD_SLOT = 3'd4;

    // Write strobes from the sequencer to the task table
    typedef struct packed {
        logic wr_en;
        logic set_ready;
        logic clr_ready;
    } tbl_cmd_t;

    // Registered read word of the task table
    typedef struct packed {
        logic              used;
        logic              ready;
        logic [PRIO_W-1:0] prio;
        logic [RT_W-1:0]   rt;
    } tbl_rd_t;

endpackage

// ===== rtl/core/ttws_if.sv =====
// Valid/ready channel interfaces for command and response words.
interface ttws_req_if;
    logic                         valid;
    logic                         ready;
    logic [ttws_pkg::CMD_W-1:0]   command;
    logic [ttws_pkg::PRIO_W-1:0]  prio;
    logic [ttws_pkg::SLOT_W-1:0]  slot;
    logic [ttws_pkg::TICK_W-1:0]  ticks;

    modport source (output valid, command, prio, slot, ticks, input ready);
    modport sink   (input valid, command, prio, slot, ticks, output ready);
endinterface

interface ttws_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ttws_pkg::CODE_W-1:0]   code;
    logic [ttws_pkg::CHOSEN_W-1:0] chosen;

    modport source (output valid, code, chosen, input ready);
    modport sink   (input valid, code, chosen, output ready);
endinterface

// ===== rtl/core/ttws_alu.sv =====
// Shared arithmetic unit: exact virtual-time compare and saturating runtime add.
module ttws_alu
(
    input  logic [ttws_pkg::RT_W-1:0]   a_rt,
    input  logic [ttws_pkg::PRIO_W-1:0] a_pr,
    input  logic [ttws_pkg::RT_W-1:0]   b_rt,
    input  logic [ttws_pkg::PRIO_W-1:0] b_pr,
    output logic                        lt,
    output logic [ttws_pkg::RT_W-1:0]   sum
);

    logic [ttws_pkg::PROD_W-1:0] prod_a;
    logic [ttws_pkg::PROD_W-1:0] prod_b;
    logic [ttws_pkg::RT_W:0]     sum_wide;

    // Cross-multiply: a_rt/a_pr < b_rt/b_pr
    assign prod_a = ttws_pkg::PROD_W'(a_rt) * ttws_pkg::PROD_W'(b_pr);
    assign prod_b = ttws_pkg::PROD_W'(b_rt) * ttws_pkg::PROD_W'(a_pr);
    assign lt     = (prod_a < prod_b);

    // Add and clamp at all ones on carry out
    assign sum_wide = {1'b0, a_rt} + {1'b0, b_rt};
    assign sum      = sum_wide[ttws_pkg::RT_W] ? '1 : sum_wide[ttws_pkg::RT_W-1:0];

endmodule

// ===== rtl/core/ttws_table.sv =====
// Task table: slot status flags plus priority/runtime memory with registered read.
module ttws_table
#(
    parameter int NUM_SLOTS = 32,
    localparam int SW = $clog2(NUM_SLOTS)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ttws_pkg::tbl_cmd_t          cmd,
    input  logic [SW-1:0]               wr_addr,
    input  logic [ttws_pkg::PRIO_W-1:0] wr_prio,
    input  logic [ttws_pkg::RT_W-1:0]   wr_rt,
    input  logic [SW-1:0]               rd_addr,
    output ttws_pkg::tbl_rd_t           rd
);

    localparam int WORD_W = ttws_pkg::PRIO_W + ttws_pkg::RT_W;

    logic [NUM_SLOTS-1:0] used_reg;
    logic [NUM_SLOTS-1:0] ready_reg;
    logic                 used_rd_reg;
    logic                 ready_rd_reg;
    logic [WORD_W-1:0]    word_rd_reg;
    logic [WORD_W-1:0]    mem_q [NUM_SLOTS];

    // Update slot status flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            ready_reg <= '0;
        end
        else
        begin
            if (cmd.set_ready)
            begin
                used_reg[wr_addr]  <= 1'b1;
                ready_reg[wr_addr] <= 1'b1;
            end
            if (cmd.clr_ready)
            begin
                ready_reg[wr_addr] <= 1'b0;
            end
        end
    end

    // Register the status of the addressed slot alongside the memory word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_rd_reg  <= 1'b0;
            ready_rd_reg <= 1'b0;
        end
        else
        begin
            used_rd_reg  <= used_reg[rd_addr];
            ready_rd_reg <= ready_reg[rd_addr];
        end
    end

    // Priority and runtime memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_q[wr_addr] <= {wr_prio, wr_rt};
        end
        word_rd_reg <= mem_q[rd_addr];
    end

    assign rd.used  = used_rd_reg;
    assign rd.ready = ready_rd_reg;
    assign rd.prio  = word_rd_reg[WORD_W-1:ttws_pkg::RT_W];
    assign rd.rt    = word_rd_reg[ttws_pkg::RT_W-1:0];

endmodule

// ===== rtl/core/task_table_weighted_scheduler_unit.sv =====
// Top level of the task table weighted scheduler: command sequencer and response register.
// One command word in gives one response word out. Create and schedule step through every
// slot, one per cycle, reading the priority/runtime memory; schedule runs the shared
// cross-multiply compare on each entry, create takes the first unused slot, then both
// drain and finish. Charge and retire read the addressed slot once and write it back,
// then finish. A create with a priority above MAX_PRIO goes straight to the done state.
// The command side is ready only while no command is in work; the response sits in an
// output register, so a new command is taken while a response waits.
module task_table_weighted_scheduler_unit
#(
    parameter int NUM_SLOTS = 32,
    parameter int MAX_PRIO  = 31
)
(
    input  logic            clk,
    input  logic            rst_n,
    ttws_req_if.sink        req,
    ttws_rsp_if.source      rsp
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);
    localparam logic [ttws_pkg::WIDE_W-1:0] NUM_WIDE = ttws_pkg::WIDE_W'(NUM_SLOTS);
    localparam logic [ttws_pkg::WIDE_W-1:0] MAX_WIDE = ttws_pkg::WIDE_W'(MAX_PRIO);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [ttws_pkg::CMD_W-1:0]    op_reg, op_next;
    logic [ttws_pkg::PRIO_W-1:0]   prio_reg, prio_next;
    logic [ttws_pkg::TICK_W-1:0]   ticks_reg, ticks_next;
    logic [SW-1:0]                 slot_idx_reg, slot_idx_next;
    logic                          in_range_reg, in_range_next;
    logic [SW-1:0]                 cnt_reg, cnt_next;
    logic                          pend_reg, pend_next;
    logic [SW-1:0]                 pend_idx_reg, pend_idx_next;
    logic                          found_reg, found_next;
    logic [SW-1:0]                 best_reg, best_next;
    logic [ttws_pkg::RT_W-1:0]     best_rt_reg, best_rt_next;
    logic [ttws_pkg::PRIO_W-1:0]   best_pr_reg, best_pr_next;
    logic [ttws_pkg::CODE_W-1:0]   res_code_reg, res_code_next;
    logic [ttws_pkg::CHOSEN_W-1:0] res_chosen_reg, res_chosen_next;
    logic                          out_valid_reg;
    logic [ttws_pkg::CODE_W-1:0]   out_code_reg;
    logic [ttws_pkg::CHOSEN_W-1:0] out_chosen_reg;

    logic [ttws_pkg::WIDE_W-1:0]   slot_wide;
    logic [ttws_pkg::WIDE_W-1:0]   prio_wide;
    logic [ttws_pkg::WIDE_W-1:0]   best_wide;

    ttws_pkg::tbl_cmd_t            tcmd;
    ttws_pkg::tbl_rd_t             rd;
    logic [SW-1:0]                 wr_addr;
    logic [ttws_pkg::PRIO_W-1:0]   wr_prio;
    logic [ttws_pkg::RT_W-1:0]     wr_rt;
    logic [SW-1:0]                 rd_addr;
    logic [ttws_pkg::RT_W-1:0]     alu_b_rt;
    logic                          alu_lt;
    logic [ttws_pkg::RT_W-1:0]     alu_sum;

    ttws_table #(.NUM_SLOTS(NUM_SLOTS)) u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tcmd),
        .wr_addr (wr_addr),
        .wr_prio (wr_prio),
        .wr_rt   (wr_rt),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    // Candidate against current best, or runtime plus ticks during charge
    assign alu_b_rt = (state_reg == S_CHK) ? ttws_pkg::RT_W'(ticks_reg) : best_rt_reg;

    ttws_alu u_alu
    (
        .a_rt (rd.rt),
        .a_pr (rd.prio),
        .b_rt (alu_b_rt),
        .b_pr (best_pr_reg),
        .lt   (alu_lt),
        .sum  (alu_sum)
    );

    assign slot_wide = ttws_pkg::WIDE_W'(req.slot);
    assign prio_wide = ttws_pkg::WIDE_W'(req.prio);

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.code   = out_code_reg;
    assign rsp.chosen = out_chosen_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        prio_next       = prio_reg;
        ticks_next      = ticks_reg;
        slot_idx_next   = slot_idx_reg;
        in_range_next   = in_range_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_rt_next    = best_rt_reg;
        best_pr_next    = best_pr_reg;
        res_code_next   = res_code_reg;
        res_chosen_next = res_chosen_reg;
        tcmd            = '0;
        wr_addr         = pend_idx_reg;
        wr_prio         = prio_reg;
        wr_rt           = '0;
        rd_addr         = slot_idx_reg;
        best_wide       = '0;

        // Evaluate the entry read in the previous scan cycle
        if (pend_reg)
        begin
            if (op_reg == ttws_pkg::CMD_CREATE)
            begin
                if (!found_reg && !rd.used)
                begin
                    tcmd.wr_en     = 1'b1;
                    tcmd.set_ready = 1'b1;
                    found_next     = 1'b1;
                    best_next      = pend_idx_reg;
                end
            end
            else if (rd.ready && (rd.prio != '0) && (!found_reg || alu_lt))
            begin
                found_next   = 1'b1;
                best_next    = pend_idx_reg;
                best_rt_next = rd.rt;
                best_pr_next = rd.prio;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.command;
                    prio_next       = req.prio;
                    ticks_next      = req.ticks;
                    slot_idx_next   = slot_wide[SW-1:0];
                    in_range_next   = (slot_wide < NUM_WIDE);
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    res_chosen_next = '0;
                    if (req.command == ttws_pkg::CMD_CREATE && prio_wide > MAX_WIDE)
                    begin
                        res_code_next = ttws_pkg::CODE_BAD_PRIO;
                        state_next    = S_DONE;
                    end
                    else if (req.command == ttws_pkg::CMD_CREATE ||
                             req.command == ttws_pkg::CMD_SCHEDULE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_SCAN:
            begin
                rd_addr       = cnt_reg;
                pend_next     = 1'b1;
                pend_idx_next = cnt_reg;
                cnt_next      = cnt_reg + SW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // Last entry is evaluated above in this cycle
                best_wide = ttws_pkg::WIDE_W'(best_next);
                if (found_next)
                begin
                    res_code_next   = ttws_pkg::CODE_OK;
                    res_chosen_next = best_wide[ttws_pkg::CHOSEN_W-1:0];
                end
                else
                begin
                    res_code_next   = (op_reg == ttws_pkg::CMD_CREATE) ?
                                      ttws_pkg::CODE_FULL : ttws_pkg::CODE_IDLE;
                    res_chosen_next = '0;
                end
                state_next = S_DONE;
            end
            S_RD:
            begin
                rd_addr    = slot_idx_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                wr_addr         = slot_idx_reg;
                res_chosen_next = '0;
                if (!in_range_reg || !rd.ready)
                begin
                    res_code_next = ttws_pkg::CODE_BAD_SLOT;
                end
                else
                begin
                    res_code_next = ttws_pkg::CODE_OK;
                    if (op_reg == ttws_pkg::CMD_CHARGE)
                    begin
                        tcmd.wr_en = 1'b1;
                        wr_prio    = rd.prio;
                        wr_rt      = alu_sum;
                    end
                    else
                    begin
                        tcmd.clr_ready = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold command fields, scan progress and response words
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        prio_reg       <= prio_next;
        ticks_reg      <= ticks_next;
        slot_idx_reg   <= slot_idx_next;
        in_range_reg   <= in_range_next;
        cnt_reg        <= cnt_next;
        pend_idx_reg   <= pend_idx_next;
        best_reg       <= best_next;
        best_rt_reg    <= best_rt_next;
        best_pr_reg    <= best_pr_next;
        res_code_reg   <= res_code_next;
        res_chosen_reg <= res_chosen_next;
        if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_code_reg   <= res_code_reg;
            out_chosen_reg <= res_chosen_reg;
        end
    end

endmodule

// ===== rtl/core/ttws_checker.sv =====
// Port-level assertions for the scheduler top level, with the bind that attaches them.
module ttws_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [ttws_pkg::CODE_W-1:0]   rsp_code,
    input  logic [ttws_pkg::CHOSEN_W-1:0] rsp_chosen
);

    // One command in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("command side ready right after accepting a word");

    // Stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_code) && $stable(rsp_chosen)))
        else $error("stalled response word changed");

    // Only defined result codes
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_code <= ttws_pkg::CODE_BAD_SLOT))
        else $error("undefined result code");

    // Error responses carry no slot
    a_err_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_code != ttws_pkg::CODE_OK) |-> (rsp_chosen == '0))
        else $error("error response with nonzero slot");

endmodule

bind task_table_weighted_scheduler_unit ttws_checker u_ttws_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_code   (rsp.code),
    .rsp_chosen (rsp.chosen)
);
